// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the token structure checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

// File: sv/jtsc_pkg.sv
// Types, codes and constants of the JSON token structure checker.
package jtsc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LVL_W       = $clog2(STACK_DEPTH);
    localparam int ADDR_W      = ($clog2(STACK_DEPTH - 1) < 1) ? 1 : $clog2(STACK_DEPTH - 1);
    localparam int NEST_W      = 6;

    typedef enum logic [3:0] {
        OP_EOF     = 4'd0,
        OP_LEXERR  = 4'd1,
        OP_STRING  = 4'd2,
        OP_BOOL    = 4'd3,
        OP_NULL    = 4'd4,
        OP_LBRACE  = 4'd5,
        OP_LBRACK  = 4'd6,
        OP_INT     = 4'd7,
        OP_DOUBLE  = 4'd8,
        OP_RBRACK  = 4'd9,
        OP_RBRACE  = 4'd10,
        OP_COLON   = 4'd11,
        OP_COMMA   = 4'd12,
        OP_FINISH  = 4'd13
    } t_op;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_NULL      = 4'd1,
        EV_BOOL      = 4'd2,
        EV_STRING    = 4'd3,
        EV_INTEGER   = 4'd4,
        EV_DOUBLE    = 4'd5,
        EV_KEY       = 4'd6,
        EV_START_MAP = 4'd7,
        EV_END_MAP   = 4'd8,
        EV_START_ARR = 4'd9,
        EV_END_ARR   = 4'd10
    } t_event;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_LEXICAL   = 4'd1,
        ERR_TRAILING  = 4'd2,
        ERR_UNALLOWED = 4'd3,
        ERR_BAD_KEY   = 4'd4,
        ERR_NO_COLON  = 4'd5,
        ERR_AFTER_MAP = 4'd6,
        ERR_AFTER_ARR = 4'd7,
        ERR_PREMATURE = 4'd8,
        ERR_TOO_DEEP  = 4'd9
    } t_err;

    typedef enum logic [3:0] {
        ST_START        = 4'd0,
        ST_COMPLETE     = 4'd1,
        ST_PARSE_ERR    = 4'd2,
        ST_LEX_ERR      = 4'd3,
        ST_MAP_START    = 4'd4,
        ST_MAP_SEP      = 4'd5,
        ST_MAP_NEED_VAL = 4'd6,
        ST_MAP_GOT_VAL  = 4'd7,
        ST_MAP_NEED_KEY = 4'd8,
        ST_ARR_START    = 4'd9,
        ST_ARR_GOT_VAL  = 4'd10,
        ST_ARR_NEED_VAL = 4'd11,
        ST_GOT_VALUE    = 4'd12
    } t_state;

    typedef enum logic [1:0] {
        CFG_MULTI    = 2'd0,
        CFG_TRAILING = 2'd1,
        CFG_PARTIAL  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [NEST_W-1:0] nesting_level;
        t_err              error_code;
        logic              status_error;
        logic              event_bool;
        t_event            event_res;
    } t_result;

endpackage

// File: sv/jtsc_out_buf.sv
// Output register with a skid stage for the result stream.
module jtsc_out_buf import jtsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    load_out;

    // The output stage may load when empty or when its item leaves this cycle.
    assign load_out = !r_out_v || i_ready;
    assign o_ready  = !r_skid_v;
    assign o_valid  = r_out_v;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (load_out) begin
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// File: sv/json_token_structure_checker.sv
// Top level of the JSON token structure checker: parser state, nesting stack, output stage.
// Takes one JSON token per item from a lexer and returns one result item per token,
// at one item per clock unless the sink stalls. The token kind arrives on s_axis_tuser
// and a bool token's value on s_axis_tdata[0]. Each result carries the semantic event
// (value, key, start or end of a map or array), the parse status, the sticky error
// code and the nesting depth after the token. The state of the innermost level lives
// in a register; outer levels are saved in a 63-entry stack memory, and the entry
// under the top is kept prefetched in a register so that a closing token pops in the
// same cycle. The output register and a skid stage keep the input open for one more
// item while the sink stalls. The first error is kept until reset; afterwards every
// token reports that code. The user must write the three mode registers on the plain
// config port only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module json_token_structure_checker import jtsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic        i_cfg_data,
    // token stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] bool_true, [7:1] zero
    input  logic [3:0]  s_axis_tuser,   // [3:0] opcode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] event_bool, [1] status_error,
                                        // [5:2] error_code, [11:6] nesting_level, [15:12] zero
    output logic [3:0]  m_axis_tuser    // [3:0] event_res
);

    // Mode registers
    logic r_multi;
    logic r_trail;
    logic r_partial;

    // Parser state
    t_state            r_state;
    t_err              r_err;
    logic [LVL_W-1:0]  r_level;
    t_state            r_top;      // copy of the stack entry under the current level
    t_state            r_stack [STACK_DEPTH-1];

    t_state            n_state;
    t_err              n_err;
    logic [LVL_W-1:0]  n_level;

    logic              accept;
    t_op               op;
    logic              bt;
    t_event            ev;
    logic              push_req;
    t_state            push_val;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_wa;
    logic [ADDR_W-1:0] stk_ra;
    t_result           res;
    t_result           out_res;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign op     = t_op'(s_axis_tuser);
    assign bt     = s_axis_tdata[0];

    function automatic t_state fail_state(t_err e);
        return (e == ERR_LEXICAL) ? ST_LEX_ERR : ST_PARSE_ERR;
    endfunction

    // Next-state logic for one token
    always_comb begin
        t_state s;
        t_state after;
        t_state psh;
        t_event v;
        logic   is_val;
        logic   do_pop;
        s        = r_state;
        n_err    = r_err;
        n_level  = r_level;
        ev       = EV_NONE;
        push_req = 1'b0;
        push_val = ST_START;
        after    = ST_COMPLETE;
        psh      = ST_START;
        v        = EV_NONE;
        is_val   = 1'b0;
        do_pop   = 1'b0;

        if (r_err != ERR_NONE) begin
            // hold everything once an error is stored
        end else if (op == OP_EOF) begin
            // chunk boundary: no event, no change
        end else if (op == OP_FINISH) begin
            if (s == ST_COMPLETE && r_multi) begin
                s = ST_GOT_VALUE;
            end
            if (s != ST_COMPLETE && s != ST_GOT_VALUE && !r_partial) begin
                n_err = ERR_PREMATURE;
                s     = fail_state(ERR_PREMATURE);
            end
        end else begin
            if (s == ST_COMPLETE) begin
                if (r_multi) begin
                    s = ST_GOT_VALUE;
                end else if (!r_trail) begin
                    n_err = ERR_TRAILING;
                    s     = fail_state(ERR_TRAILING);
                end
            end

            unique case (s)
                ST_START, ST_GOT_VALUE, ST_MAP_NEED_VAL, ST_ARR_NEED_VAL,
                ST_ARR_START: begin
                    unique case (op)
                        OP_LEXERR: begin
                            n_err = ERR_LEXICAL;
                        end
                        OP_STRING: begin
                            v = EV_STRING;  is_val = 1'b1;
                        end
                        OP_BOOL: begin
                            v = EV_BOOL;    is_val = 1'b1;
                        end
                        OP_NULL: begin
                            v = EV_NULL;    is_val = 1'b1;
                        end
                        OP_LBRACE: begin
                            v = EV_START_MAP; is_val = 1'b1; psh = ST_MAP_START;
                        end
                        OP_LBRACK: begin
                            v = EV_START_ARR; is_val = 1'b1; psh = ST_ARR_START;
                        end
                        OP_INT: begin
                            v = EV_INTEGER; is_val = 1'b1;
                        end
                        OP_DOUBLE: begin
                            v = EV_DOUBLE;  is_val = 1'b1;
                        end
                        OP_RBRACK: begin
                            if (s == ST_ARR_START) begin
                                ev     = EV_END_ARR;
                                do_pop = 1'b1;
                            end else begin
                                n_err = ERR_UNALLOWED;
                            end
                        end
                        default: begin
                            n_err = ERR_UNALLOWED;
                        end
                    endcase
                    if (n_err != ERR_NONE) begin
                        s = fail_state(n_err);
                    end else if (is_val) begin
                        if (psh != ST_START && r_level >= LVL_W'(STACK_DEPTH - 1)) begin
                            n_err = ERR_TOO_DEEP;
                            s     = fail_state(ERR_TOO_DEEP);
                        end else begin
                            if (s == ST_START || s == ST_GOT_VALUE) begin
                                after = ST_COMPLETE;
                            end else if (s == ST_MAP_NEED_VAL) begin
                                after = ST_MAP_GOT_VAL;
                            end else begin
                                after = ST_ARR_GOT_VAL;
                            end
                            ev = v;
                            if (psh != ST_START) begin
                                push_req = 1'b1;
                                push_val = after;
                                n_level  = LVL_W'(r_level + 1'b1);
                                s        = psh;
                            end else begin
                                s = after;
                            end
                        end
                    end
                end
                ST_MAP_START, ST_MAP_NEED_KEY: begin
                    if (op == OP_LEXERR) begin
                        n_err = ERR_LEXICAL;
                        s     = fail_state(ERR_LEXICAL);
                    end else if (op == OP_STRING) begin
                        ev = EV_KEY;
                        s  = ST_MAP_SEP;
                    end else if (op == OP_RBRACE && s == ST_MAP_START) begin
                        ev     = EV_END_MAP;
                        do_pop = 1'b1;
                    end else begin
                        n_err = ERR_BAD_KEY;
                        s     = fail_state(ERR_BAD_KEY);
                    end
                end
                ST_MAP_SEP: begin
                    if (op == OP_COLON) begin
                        s = ST_MAP_NEED_VAL;
                    end else if (op == OP_LEXERR) begin
                        n_err = ERR_LEXICAL;
                        s     = fail_state(ERR_LEXICAL);
                    end else begin
                        n_err = ERR_NO_COLON;
                        s     = fail_state(ERR_NO_COLON);
                    end
                end
                ST_MAP_GOT_VAL: begin
                    if (op == OP_RBRACE) begin
                        ev     = EV_END_MAP;
                        do_pop = 1'b1;
                    end else if (op == OP_COMMA) begin
                        s = ST_MAP_NEED_KEY;
                    end else if (op == OP_LEXERR) begin
                        n_err = ERR_LEXICAL;
                        s     = fail_state(ERR_LEXICAL);
                    end else begin
                        n_err = ERR_AFTER_MAP;
                        s     = fail_state(ERR_AFTER_MAP);
                    end
                end
                ST_ARR_GOT_VAL: begin
                    if (op == OP_RBRACK) begin
                        ev     = EV_END_ARR;
                        do_pop = 1'b1;
                    end else if (op == OP_COMMA) begin
                        s = ST_ARR_NEED_VAL;
                    end else if (op == OP_LEXERR) begin
                        n_err = ERR_LEXICAL;
                        s     = fail_state(ERR_LEXICAL);
                    end else begin
                        n_err = ERR_AFTER_ARR;
                        s     = fail_state(ERR_AFTER_ARR);
                    end
                end
                default: begin
                    // complete with trailing tokens ignored, or an error state
                end
            endcase

            // Pop restores the saved outer state; an empty stack falls back to start.
            if (do_pop) begin
                if (r_level == '0) begin
                    s = ST_START;
                end else begin
                    n_level = LVL_W'(r_level - 1'b1);
                    s       = r_top;
                end
            end
        end
        n_state = s;
    end

    // Stack write at the current level, prefetch read of the entry under the next level
    assign stk_we = accept && push_req;
    assign stk_wa = r_level[ADDR_W-1:0];
    assign stk_ra = ADDR_W'(n_level - 1'b1);

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa] <= push_val;
        end
        if (accept && n_level != '0) begin
            // forward a push into the same slot
            r_top <= (stk_we && stk_wa == stk_ra) ? push_val : r_stack[stk_ra];
        end
    end

    // Control state and mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_START;
            r_err     <= ERR_NONE;
            r_level   <= '0;
            r_multi   <= 1'b0;
            r_trail   <= 1'b0;
            r_partial <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_err   <= n_err;
                r_level <= n_level;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MULTI:    r_multi   <= i_cfg_data;
                    CFG_TRAILING: r_trail   <= i_cfg_data;
                    CFG_PARTIAL:  r_partial <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Assemble the result of this token
    always_comb begin
        res.event_res     = ev;
        res.event_bool    = (ev == EV_BOOL) ? bt : 1'b0;
        res.status_error  = (n_err != ERR_NONE);
        res.error_code    = n_err;
        res.nesting_level = NEST_W'(n_level);
    end

    jtsc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tuser = out_res.event_res;
    assign m_axis_tdata = {4'b0000, out_res.nesting_level, out_res.error_code,
                           out_res.status_error, out_res.event_bool};

    // Checks
    `ASSERT_CLKD(a_level_in_range, i_clk, i_rst_n, r_level <= LVL_W'(STACK_DEPTH - 1))
    `ASSERT_CLKD(a_err_sticky, i_clk, i_rst_n, (r_err != ERR_NONE) |=> (r_err == $past(r_err)))
    `ASSERT_CLKD(a_err_state, i_clk, i_rst_n,
        (r_err != ERR_NONE) == (r_state == ST_PARSE_ERR || r_state == ST_LEX_ERR))
    `ASSERT_CLKD(a_level_hold, i_clk, i_rst_n, !accept |=> $stable(r_level))
    `ASSERT_CLKD(a_stall_needs_out, i_clk, i_rst_n, !s_axis_tready |-> m_axis_tvalid)

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the JSON token structure checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jtsc_pkg::*;

    // Opcodes the lexer never produces; the block must treat them as bad tokens.
    localparam logic [3:0] OP_SPARE_LO = 4'd14;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    localparam int IDLE_PCT       = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_MULTI;
    logic        i_cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [0] bool_true, [7:1] zero
    logic [3:0]  s_axis_tuser = OP_EOF; // [3:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [0] event_bool, [1] status_error,
                                        // [5:2] error_code, [11:6] nesting_level
    logic [3:0]  m_axis_tuser;          // [3:0] event_res

    json_token_structure_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser mirror: mode bits, innermost state, saved outer states,
    // depth and the sticky error code.
    // ------------------------------------------------------------------
    logic        multi_ok   = 1'b0;
    logic        trail_ok   = 1'b0;
    logic        partial_ok = 1'b0;
    t_state      tok_state  = ST_START;
    t_state      nest_mem [STACK_DEPTH-1];
    int unsigned depth_lvl  = 0;
    t_err        err_code   = ERR_NONE;

    t_result     parse_results[$];   // results still owed by the block, oldest first
    int          mismatch_count = 0;
    bit          steady = 1'b0;      // suppress idling on both sides while set

    function automatic void raise_error(t_err code);
        err_code  = code;
        tok_state = (code == ERR_LEXICAL) ? ST_LEX_ERR : ST_PARSE_ERR;
    endfunction

    function automatic void close_level();
        if (depth_lvl == 0) begin
            tok_state = ST_START;
        end else begin
            depth_lvl--;
            tok_state = nest_mem[depth_lvl];
        end
    endfunction

    // Token where a value is expected; returns the event it produces.
    function automatic t_event take_value(logic [3:0] op);
        t_event ev;
        t_state opened;
        t_state was;
        opened = ST_START;
        was    = tok_state;
        case (op)
            OP_LEXERR: begin
                raise_error(ERR_LEXICAL);
                return EV_NONE;
            end
            OP_STRING: ev = EV_STRING;
            OP_BOOL:   ev = EV_BOOL;
            OP_NULL:   ev = EV_NULL;
            OP_INT:    ev = EV_INTEGER;
            OP_DOUBLE: ev = EV_DOUBLE;
            OP_LBRACE: begin
                ev     = EV_START_MAP;
                opened = ST_MAP_START;
            end
            OP_LBRACK: begin
                ev     = EV_START_ARR;
                opened = ST_ARR_START;
            end
            OP_RBRACK: begin
                // only an empty array may close where a value is expected
                if (was == ST_ARR_START) begin
                    close_level();
                    return EV_END_ARR;
                end
                raise_error(ERR_UNALLOWED);
                return EV_NONE;
            end
            default: begin
                raise_error(ERR_UNALLOWED);
                return EV_NONE;
            end
        endcase
        if (opened != ST_START && depth_lvl >= STACK_DEPTH - 1) begin
            raise_error(ERR_TOO_DEEP);
            return EV_NONE;
        end
        if (was == ST_START || was == ST_GOT_VALUE)
            tok_state = ST_COMPLETE;
        else if (was == ST_MAP_NEED_VAL)
            tok_state = ST_MAP_GOT_VAL;
        else
            tok_state = ST_ARR_GOT_VAL;
        if (opened != ST_START) begin
            nest_mem[depth_lvl] = tok_state;
            depth_lvl++;
            tok_state = opened;
        end
        return ev;
    endfunction

    // Advance the mirror by one token and return the result the block owes.
    function automatic t_result parse_token(logic [3:0] op, logic bt);
        t_result r;
        t_event  ev;
        ev = EV_NONE;
        // a stored error freezes everything; end of chunk never changes state
        if (err_code == ERR_NONE && op != OP_EOF) begin
            if (op == OP_FINISH) begin
                if (tok_state == ST_COMPLETE && multi_ok)
                    tok_state = ST_GOT_VALUE;
                if (tok_state != ST_COMPLETE && tok_state != ST_GOT_VALUE && !partial_ok)
                    raise_error(ERR_PREMATURE);
            end else begin
                if (tok_state == ST_COMPLETE) begin
                    if (multi_ok)
                        tok_state = ST_GOT_VALUE;
                    else if (!trail_ok)
                        raise_error(ERR_TRAILING);
                end
                case (tok_state)
                    ST_START, ST_GOT_VALUE, ST_MAP_NEED_VAL, ST_ARR_NEED_VAL,
                    ST_ARR_START: begin
                        ev = take_value(op);
                    end
                    ST_MAP_START, ST_MAP_NEED_KEY: begin
                        if (op == OP_LEXERR) begin
                            raise_error(ERR_LEXICAL);
                        end else if (op == OP_STRING) begin
                            ev        = EV_KEY;
                            tok_state = ST_MAP_SEP;
                        end else if (op == OP_RBRACE && tok_state == ST_MAP_START) begin
                            ev = EV_END_MAP;
                            close_level();
                        end else begin
                            raise_error(ERR_BAD_KEY);
                        end
                    end
                    ST_MAP_SEP: begin
                        if (op == OP_COLON)       tok_state = ST_MAP_NEED_VAL;
                        else if (op == OP_LEXERR) raise_error(ERR_LEXICAL);
                        else                      raise_error(ERR_NO_COLON);
                    end
                    ST_MAP_GOT_VAL: begin
                        if (op == OP_RBRACE) begin
                            ev = EV_END_MAP;
                            close_level();
                        end else if (op == OP_COMMA) begin
                            tok_state = ST_MAP_NEED_KEY;
                        end else if (op == OP_LEXERR) begin
                            raise_error(ERR_LEXICAL);
                        end else begin
                            raise_error(ERR_AFTER_MAP);
                        end
                    end
                    ST_ARR_GOT_VAL: begin
                        if (op == OP_RBRACK) begin
                            ev = EV_END_ARR;
                            close_level();
                        end else if (op == OP_COMMA) begin
                            tok_state = ST_ARR_NEED_VAL;
                        end else if (op == OP_LEXERR) begin
                            raise_error(ERR_LEXICAL);
                        end else begin
                            raise_error(ERR_AFTER_ARR);
                        end
                    end
                    default: begin
                        // trailing token ignored, or already in an error state
                    end
                endcase
            end
        end
        r.event_res     = ev;
        r.event_bool    = (ev == EV_BOOL) ? bt : 1'b0;
        r.status_error  = (err_code != ERR_NONE);
        r.error_code    = err_code;
        r.nesting_level = depth_lvl[NEST_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Token choice: pick a token the current state accepts. With wind_down
    // set, head straight for depth zero (no opens, no commas).
    // ------------------------------------------------------------------
    function automatic logic [3:0] pick_legal(int max_depth, bit wind_down);
        logic [3:0] picks[$];
        t_state     s;
        bit         finish_ok;
        s         = tok_state;
        finish_ok = (s == ST_COMPLETE || s == ST_GOT_VALUE || partial_ok);
        if (!wind_down) begin
            if ($urandom_range(0, 99) < 4) return OP_EOF;
            if (finish_ok && $urandom_range(0, 99) < 4) return OP_FINISH;
        end
        if (s == ST_COMPLETE && multi_ok)
            s = ST_GOT_VALUE;
        case (s)
            ST_START, ST_GOT_VALUE, ST_MAP_NEED_VAL, ST_ARR_NEED_VAL, ST_ARR_START: begin
                if (wind_down && s == ST_ARR_START) begin
                    picks.push_back(OP_RBRACK);
                end else begin
                    picks = '{OP_STRING, OP_BOOL, OP_NULL, OP_INT, OP_DOUBLE};
                    if (!wind_down && depth_lvl < max_depth)
                        picks = {picks, OP_LBRACE, OP_LBRACE, OP_LBRACK, OP_LBRACK};
                    if (!wind_down && s == ST_ARR_START)
                        picks = {picks, OP_RBRACK, OP_RBRACK};
                end
            end
            ST_MAP_START: begin
                picks.push_back(OP_RBRACE);
                if (!wind_down) picks.push_back(OP_STRING);
            end
            ST_MAP_NEED_KEY: picks.push_back(OP_STRING);
            ST_MAP_SEP:      picks.push_back(OP_COLON);
            ST_MAP_GOT_VAL: begin
                picks.push_back(OP_RBRACE);
                if (!wind_down) picks.push_back(OP_COMMA);
            end
            ST_ARR_GOT_VAL: begin
                picks.push_back(OP_RBRACK);
                if (!wind_down) picks.push_back(OP_COMMA);
            end
            ST_COMPLETE: begin
                // trailing garbage on: any opcode at all is swallowed
                if (trail_ok) return 4'($urandom_range(0, 15));
            end
            default: ;
        endcase
        if (picks.size() == 0)
            return $urandom_range(0, 1) ? OP_EOF : OP_FINISH;
        return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Driving: inputs change at the falling edge, handshakes are sampled
    // at the rising edge.
    // ------------------------------------------------------------------
    task automatic send_token(logic [3:0] op, logic bt);
        // idle the sender at random unless a steady stretch is running
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, bt};
        do @(posedge i_clk); while (!s_axis_tready);
        parse_results.push_back(parse_token(op, bt));
        @(negedge i_clk);
    endtask

    task automatic walk_tokens(int n, int max_depth);
        repeat (n) send_token(pick_legal(max_depth, 1'b0), 1'($urandom_range(0, 1)));
    endtask

    task automatic close_all();
        while (depth_lvl != 0 && err_code == ERR_NONE)
            send_token(pick_legal(0, 1'b1), 1'($urandom_range(0, 1)));
    endtask

    // Stop sending and let every owed result come back before touching modes.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (parse_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all three mode registers one after another; call only when drained.
    task automatic set_modes(logic multi, logic trail, logic partial);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MULTI;
        i_cfg_data <= multi;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TRAILING;
        i_cfg_data <= trail;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PARTIAL;
        i_cfg_data <= partial;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        multi_ok   = multi;
        trail_ok   = trail;
        partial_ok = partial;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every token kind but LEXERR in one nested value under reset modes, both bool
    // values, a bool flag on a non-bool token, EOF at start, finish once complete.
    task automatic test_value_kinds();
        send_token(OP_EOF,    1'b1);
        send_token(OP_LBRACK, 1'b0);
        send_token(OP_BOOL,   1'b1);
        send_token(OP_COMMA,  1'b0);
        send_token(OP_BOOL,   1'b0);
        send_token(OP_COMMA,  1'b0);
        send_token(OP_NULL,   1'b1);
        send_token(OP_COMMA,  1'b0);
        send_token(OP_STRING, 1'b0);
        send_token(OP_COMMA,  1'b0);
        send_token(OP_INT,    1'b0);
        send_token(OP_COMMA,  1'b0);
        send_token(OP_DOUBLE, 1'b1);
        send_token(OP_COMMA,  1'b0);
        send_token(OP_LBRACE, 1'b0);
        send_token(OP_STRING, 1'b0);
        send_token(OP_COLON,  1'b0);
        send_token(OP_LBRACK, 1'b0);
        send_token(OP_RBRACK, 1'b0);
        send_token(OP_COMMA,  1'b0);
        send_token(OP_STRING, 1'b0);
        send_token(OP_COLON,  1'b0);
        send_token(OP_LBRACE, 1'b0);
        send_token(OP_RBRACE, 1'b0);
        send_token(OP_RBRACE, 1'b0);
        send_token(OP_RBRACK, 1'b0);
        send_token(OP_FINISH, 1'b0);
    endtask

    // After a complete value with trailing garbage on, even a lexer error
    // and the spare opcodes are swallowed.
    task automatic test_trailing_garbage();
        drain();
        set_modes(1'b0, 1'b1, 1'b0);
        send_token(OP_LEXERR,   1'b0);
        send_token(OP_SPARE_LO, 1'b1);
        send_token(OP_SPARE_HI, 1'b1);
        send_token(OP_COMMA,    1'b0);
        send_token(OP_STRING,   1'b0);
        send_token(OP_FINISH,   1'b0);
    endtask

    // Finish inside an open map and an open array, then close them.
    task automatic test_partial_finish();
        drain();
        set_modes(1'b1, 1'b0, 1'b1);
        send_token(OP_LBRACE, 1'b0);
        send_token(OP_FINISH, 1'b0);
        send_token(OP_RBRACE, 1'b0);
        send_token(OP_LBRACK, 1'b0);
        send_token(OP_FINISH, 1'b0);
        send_token(OP_RBRACK, 1'b0);
    endtask

    // Fill the whole stack with alternating arrays and maps, then unwind,
    // with no idling on either side.
    task automatic test_deep_nesting();
        drain();
        set_modes(1'b1, 1'b0, 1'b0);
        steady = 1'b1;
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            if (i % 2) begin
                send_token(OP_LBRACE, 1'b0);
                send_token(OP_STRING, 1'b0);
                send_token(OP_COLON,  1'b0);
            end else begin
                send_token(OP_LBRACK, 1'b0);
            end
        end
        close_all();
        steady = 1'b0;
    endtask

    // Well-formed token walks under a mode setting chosen anew for each phase.
    task automatic test_random_phases();
        logic multi;
        logic trail;
        logic partial;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            multi   = (p % 4 != 3);
            trail   = 1'($urandom_range(0, 1));
            partial = 1'($urandom_range(0, 1));
            if (p == 0) begin
                multi   = 1'b1;
                trail   = 1'b1;
                partial = 1'b1;
            end
            set_modes(multi, trail, partial);
            steady = (p == 2);
            walk_tokens(PHASE_ITEMS, $urandom_range(1, 10));
            steady = 1'b0;
        end
    endtask

    // Drive the parser into one error, picked at random, then keep sending
    // noise to check that the code sticks and everything else is ignored.
    task automatic test_error_sticky();
        logic bad_open;
        drain();
        set_modes(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        close_all();
        case ($urandom_range(0, 2))
            0: begin
                // too deep: fill the stack, then one more opener
                repeat (STACK_DEPTH - 1) send_token(OP_LBRACK, 1'b0);
                bad_open = 1'($urandom_range(0, 1));
                if (bad_open) send_token(OP_LBRACE, 1'b0);
                else          send_token(OP_LBRACK, 1'b0);
            end
            1: begin
                // premature end: finish inside an open array
                send_token(OP_LBRACK, 1'b0);
                drain();
                set_modes(1'b1, trail_ok, 1'b0);
                send_token(OP_FINISH, 1'b0);
            end
            default: walk_tokens($urandom_range(0, 20), 4);
        endcase
        while (err_code == ERR_NONE)
            send_token(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        repeat (60) send_token(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Sink side: stall at random unless a steady stretch is running.
    // ------------------------------------------------------------------
    always @(negedge i_clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // ------------------------------------------------------------------
    // Result checking against the oldest owed result.
    // ------------------------------------------------------------------
    function automatic void flag_field(string field, logic [7:0] want, logic [7:0] got);
        mismatch_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    t_result owed;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (parse_results.size() == 0) begin
                mismatch_count++;
                $error("result item arrived with none pending");
            end else begin
                owed = parse_results.pop_front();
                if (m_axis_tuser !== owed.event_res)
                    flag_field("event_res", 8'(owed.event_res), 8'(m_axis_tuser));
                if (m_axis_tdata[0] !== owed.event_bool)
                    flag_field("event_bool", 8'(owed.event_bool), 8'(m_axis_tdata[0]));
                if (m_axis_tdata[1] !== owed.status_error)
                    flag_field("status_error", 8'(owed.status_error), 8'(m_axis_tdata[1]));
                if (m_axis_tdata[5:2] !== owed.error_code)
                    flag_field("error_code", 8'(owed.error_code), 8'(m_axis_tdata[5:2]));
                if (m_axis_tdata[11:6] !== owed.nesting_level)
                    flag_field("nesting_level", 8'(owed.nesting_level),
                               8'(m_axis_tdata[11:6]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no item moves on either side for too long.
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed tests, random phases, error, then wrap up.
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_value_kinds();
        test_trailing_garbage();
        test_partial_finish();
        test_deep_nesting();
        test_random_phases();
        test_error_sticky();

        // hold off the sender, let the last results arrive, then settle
        s_axis_tvalid <= 1'b0;
        while (parse_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/jtsc_pkg.sv
sv/jtsc_out_buf.sv
sv/json_token_structure_checker.sv
sim/tb_top.sv
